>>> hdl/bol_pkg.sv
// Shared types and constants for the bounded ordered list unit.
`default_nettype none
package bol_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   // Request modes.
   localparam logic [1:0] MODE_INSERT   = 2'd0;
   localparam logic [1:0] MODE_DELETE   = 2'd1;
   localparam logic [1:0] MODE_TRAVERSE = 2'd2;

   // Response status codes.
   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_DELETED  = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_ELEMENT  = 3'd4;
   localparam logic [2:0] ST_EMPTY    = 3'd5;

   // Operations broadcast to every cell of the chain.
   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_PUSH   = 2'd1;
   localparam logic [1:0] CELL_PULL   = 2'd2;
   localparam logic [1:0] CELL_ROTATE = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] item_value;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] key;
   } cell_cmd_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] value;
   } cell_link_type;

endpackage
`default_nettype wire

>>> hdl/bounded_ordered_list_unit.sv
// Top level of the bounded ordered list unit: cell chain and command control.
//
//   channel   ports                      transfer
//   request   start, busy, req_item      edge with start high and busy low
//   response  rsp_strobe, rsp_item       every edge ending a strobe cycle
//
// Insert and delete answer in the cycle after the transfer, from a register.
// Traverse of n entries rotates the cell chain once per cycle and holds busy
// until the last entry has been emitted; results stream out one per cycle.
// Reset empties the list at once (cell occupancy bits only).
// The receiver cannot stall; results are never held back.
`default_nettype none
module bounded_ordered_list_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire bol_pkg::req_type req_item,
   output logic                  rsp_strobe,
   output bol_pkg::rsp_type      rsp_item
);

   localparam int DEPTH = bol_pkg::LIST_DEPTH;
   localparam int IW    = bol_pkg::IDX_W;

   bol_pkg::cell_cmd_type  cmd;
   bol_pkg::cell_link_type held [DEPTH];
   bol_pkg::cell_link_type prev_link [DEPTH];
   bol_pkg::cell_link_type next_link [DEPTH];
   logic [DEPTH:0]         found;
   logic [DEPTH-1:0]       vld;

   logic              busy_ff, busy_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic              strobe_ff, strobe_in;
   bol_pkg::rsp_type  rsp_ff, rsp_in;

   logic          accept, full, traversing, last_elem;
   logic [IW-1:0] cur_idx;
   logic [IW:0]   nxt_idx;

   assign found[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_chain
      if (i == 0) begin : g_head
         assign prev_link[i] = '{valid: 1'b1, value: req_item.value};
      end else begin : g_body
         assign prev_link[i] = held[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign next_link[i] = '{valid: 1'b0, value: 32'd0};
      end else begin : g_inner
         assign next_link[i] = held[i+1];
      end
      assign vld[i] = held[i].valid;

      bol_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .from_prev   (prev_link[i]),
         .from_next   (next_link[i]),
         .front_value (held[0].value),
         .found_in    (found[i]),
         .found_out   (found[i+1]),
         .held        (held[i])
      );
   end

   assign accept  = start && !busy_ff;
   assign full    = vld[DEPTH-1];
   assign cur_idx = busy_ff ? idx_ff : '0;
   assign nxt_idx = {1'b0, cur_idx} + (IW+1)'(1);

   always_comb begin
      if (nxt_idx == (IW+1)'(DEPTH)) begin
         last_elem = 1'b1;
      end else begin
         last_elem = !vld[nxt_idx[IW-1:0]];
      end
   end

   assign traversing = busy_ff ||
                       (accept && (req_item.mode == bol_pkg::MODE_TRAVERSE) && vld[0]);

   always_comb begin
      cmd.key = req_item.value;
      cmd.op  = bol_pkg::CELL_HOLD;
      if (traversing) begin
         cmd.op = bol_pkg::CELL_ROTATE;
      end else if (accept) begin
         case (req_item.mode)
            bol_pkg::MODE_INSERT: begin
               if (!full) begin
                  cmd.op = bol_pkg::CELL_PUSH;
               end
            end
            bol_pkg::MODE_DELETE: begin
               cmd.op = bol_pkg::CELL_PULL;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      if (traversing) begin
         // The front cell always holds the next entry to emit while rotating.
         strobe_in = 1'b1;
         rsp_in    = '{status: bol_pkg::ST_ELEMENT, item_value: held[0].value,
                       last: last_elem};
         busy_in   = !last_elem;
         idx_in    = nxt_idx[IW-1:0];
      end else if (accept) begin
         case (req_item.mode)
            bol_pkg::MODE_INSERT: begin
               strobe_in = 1'b1;
               rsp_in    = '{status: full ? bol_pkg::ST_FULL : bol_pkg::ST_INSERTED,
                             item_value: req_item.value, last: 1'b1};
            end
            bol_pkg::MODE_DELETE: begin
               strobe_in = 1'b1;
               rsp_in    = '{status: found[DEPTH] ? bol_pkg::ST_DELETED
                                                  : bol_pkg::ST_NOTFOUND,
                             item_value: req_item.value, last: 1'b1};
            end
            bol_pkg::MODE_TRAVERSE: begin
               strobe_in = 1'b1;
               rsp_in    = '{status: bol_pkg::ST_EMPTY, item_value: 32'sd0, last: 1'b1};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         idx_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         idx_ff    <= idx_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
`default_nettype wire

>>> hdl/bol_cell.sv
// One list position: holds an entry and trades it with its neighbours.
`default_nettype none
module bol_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bol_pkg::cell_cmd_type  cmd,
   input  wire bol_pkg::cell_link_type from_prev,
   input  wire bol_pkg::cell_link_type from_next,
   input  wire logic [31:0]            front_value,
   input  wire logic                   found_in,
   output logic                        found_out,
   output bol_pkg::cell_link_type      held
);

   logic        valid_ff, valid_in;
   logic [31:0] value_ff, value_in;
   logic        match;

   assign match     = valid_ff && (value_ff == cmd.key);
   assign found_out = found_in || match;
   assign held      = '{valid: valid_ff, value: value_ff};

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      case (cmd.op)
         bol_pkg::CELL_PUSH: begin
            valid_in = from_prev.valid;
            value_in = from_prev.value;
         end
         bol_pkg::CELL_PULL: begin
            // The first matching cell and every one behind it close the gap.
            if (found_out) begin
               valid_in = from_next.valid;
               value_in = from_next.value;
            end
         end
         bol_pkg::CELL_ROTATE: begin
            // The last occupied cell takes the front entry, so the list comes full circle.
            if (valid_ff) begin
               value_in = from_next.valid ? from_next.value : front_value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded ordered list unit, with a predictor and random traffic.
module tb_top;
   import bol_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int         ITEM_TARGET = 480;
   localparam int         CYCLE_LIMIT = 400000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   // Stimulus and prediction state.
   req_type     pending_cmds[$];
   rsp_type     expected_rsps[$];
   logic [31:0] list_mem[LIST_DEPTH];
   int          list_count;
   logic [31:0] gen_list[$];
   int          cycle_count;
   int          fail_count;
   int          xfer_count;
   int          ignored_count;
   int          rsp_count;
   int          full_drops;
   int          deletions;
   int          longest_walk;

   bounded_ordered_list_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Queues a command and keeps a rough copy of the list so that delete keys can hit.
   task automatic add_cmd(input logic [1:0] mode, input logic [31:0] value);
      req_type cmd;
      bit      found;
      cmd.mode  = mode;
      cmd.value = value;
      pending_cmds.push_back(cmd);
      found = 1'b0;
      if (mode == MODE_INSERT && gen_list.size() < LIST_DEPTH) begin
         gen_list.push_front(value);
      end else if (mode == MODE_DELETE) begin
         for (int i = 0; i < gen_list.size() && !found; i++) begin
            if (gen_list[i] == value) begin
               gen_list.delete(i);
               found = 1'b1;
            end
         end
      end
   endtask

   // Driver: a command stays on the port until it transfers, then an optional gap follows.
   // A transfer is recognised by the monitor's transfer count moving on.
   always @(negedge clock) begin : p_drive
      static int gap_left   = 0;
      static int burst_left = 0;
      static int seen_xfers = 0;
      int        pick;
      if (reset) begin
         start    <= 1'b0;
         req_item <= '0;
      end else if (!start || xfer_count != seen_xfers) begin
         if (xfer_count != seen_xfers) begin
            seen_xfers = xfer_count;
            pick = $urandom_range(99);
            if (burst_left > 0) begin
               burst_left--;
               gap_left = 0;
            end else if (pick < 4) begin
               burst_left = $urandom_range(60, 20);
               gap_left   = 0;
            end else if (pick < 50) begin
               gap_left = 0;
            end else if (pick < 90) begin
               gap_left = $urandom_range(3, 1);
            end else begin
               gap_left = $urandom_range(40, 12);
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            req_item <= pending_cmds.pop_front();
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks each response against the oldest prediction, then
   // updates the predicted list for a command that transfers at this edge.
   always @(posedge clock) begin : p_monitor
      rsp_type     exp_rsp;
      rsp_type     new_rsp;
      int          hit;
      logic [31:0] key;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
      if (!reset) begin
         if (rsp_strobe) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               $error("Unexpected response: status %0d item_value %0d last %0b",
                      rsp_item.status, rsp_item.item_value, rsp_item.last);
               fail_count++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_item.status !== exp_rsp.status) begin
                  $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_item.status);
                  fail_count++;
               end
               if (rsp_item.item_value !== exp_rsp.item_value) begin
                  $error("item_value: expected %0d, actual %0d",
                         exp_rsp.item_value, rsp_item.item_value);
                  fail_count++;
               end
               if (rsp_item.last !== exp_rsp.last) begin
                  $error("last: expected %0b, actual %0b", exp_rsp.last, rsp_item.last);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            xfer_count++;
            key = req_item.value;
            new_rsp.item_value = key;
            new_rsp.last       = 1'b1;
            case (req_item.mode)
               MODE_INSERT: begin
                  if (list_count >= LIST_DEPTH) begin
                     new_rsp.status = ST_FULL;
                     full_drops++;
                  end else begin
                     for (int i = list_count; i > 0; i--) list_mem[i] = list_mem[i-1];
                     list_mem[0] = key;
                     list_count++;
                     new_rsp.status = ST_INSERTED;
                  end
                  expected_rsps.push_back(new_rsp);
               end
               MODE_DELETE: begin
                  hit = -1;
                  for (int i = 0; i < list_count && hit < 0; i++) begin
                     if (list_mem[i] == key) hit = i;
                  end
                  if (hit < 0) begin
                     new_rsp.status = ST_NOTFOUND;
                  end else begin
                     for (int i = hit; i < list_count - 1; i++) list_mem[i] = list_mem[i+1];
                     list_count--;
                     new_rsp.status = ST_DELETED;
                     deletions++;
                  end
                  expected_rsps.push_back(new_rsp);
               end
               MODE_TRAVERSE: begin
                  if (list_count == 0) begin
                     new_rsp.status     = ST_EMPTY;
                     new_rsp.item_value = '0;
                     expected_rsps.push_back(new_rsp);
                  end else begin
                     for (int i = 0; i < list_count; i++) begin
                        new_rsp.status     = ST_ELEMENT;
                        new_rsp.item_value = list_mem[i];
                        new_rsp.last       = (i == list_count - 1);
                        expected_rsps.push_back(new_rsp);
                     end
                     if (list_count > longest_walk) longest_walk = list_count;
                  end
               end
               default: begin
                  // The unused mode leaves the list alone and produces nothing.
                  ignored_count++;
               end
            endcase
         end
      end
   end

   initial begin : p_stimulus
      int          real_items;
      int          phase_len;
      int          phase_kind;
      int          pick;
      logic [31:0] value;

      reset = 1'b1;

      // Directed part: empty list, extremes, duplicates, tail delete, full list.
      add_cmd(MODE_TRAVERSE, 32'h0000_1234);
      add_cmd(MODE_DELETE, 32'd7);
      add_cmd(MODE_INSERT, 32'h8000_0000);
      add_cmd(MODE_INSERT, 32'h7FFF_FFFF);
      add_cmd(MODE_INSERT, 32'h0000_0000);
      add_cmd(MODE_INSERT, 32'hFFFF_FFFF);
      add_cmd(MODE_INSERT, 32'd5);
      add_cmd(MODE_INSERT, 32'd5);
      add_cmd(MODE_TRAVERSE, 32'hFFFF_FFFF);
      add_cmd(MODE_DELETE, 32'd5);
      add_cmd(MODE_DELETE, 32'h8000_0000);
      add_cmd(MODE_DELETE, 32'h8000_0001);
      add_cmd(MODE_UNUSED, 32'hA5A5_5A5A);
      for (int i = 0; i < 12; i++) add_cmd(MODE_INSERT, 32'h100 + i);
      add_cmd(MODE_INSERT, 32'h7FFF_FFFF);
      add_cmd(MODE_TRAVERSE, 32'h0);
      add_cmd(MODE_DELETE, 32'h10B);

      // Random part in phases that lean towards filling, draining or a mix,
      // so that both the full and the empty list come round again and again.
      real_items = 0;
      while (real_items < ITEM_TARGET) begin
         phase_len  = $urandom_range(40, 10);
         phase_kind = $urandom_range(2);
         for (int n = 0; n < phase_len; n++) begin
            pick = $urandom_range(99);
            if (pick < 2) begin
               add_cmd(MODE_UNUSED, $urandom);
               continue;
            end
            real_items++;
            pick = $urandom_range(99);
            if (pick < 16) begin
               add_cmd(MODE_TRAVERSE, $urandom);
            end else if ((phase_kind == 0 && pick < 80) || (phase_kind == 1 && pick < 36) ||
                         (phase_kind == 2 && pick < 58)) begin
               pick = $urandom_range(99);
               if (pick < 35)
                  value = $urandom_range(15);
               else if (pick < 75)
                  value = $urandom;
               else if (pick < 85)
                  value = (pick[0]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
               else if (gen_list.size() > 0)
                  value = gen_list[$urandom_range(gen_list.size() - 1)];
               else
                  value = 32'hFFFF_FFFF;
               add_cmd(MODE_INSERT, value);
            end else begin
               pick = $urandom_range(99);
               if (pick < 70 && gen_list.size() > 0)
                  value = gen_list[$urandom_range(gen_list.size() - 1)];
               else if (pick < 85)
                  value = $urandom;
               else
                  value = $urandom_range(15);
               add_cmd(MODE_DELETE, value);
            end
         end
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || start) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Run covered %0d transfers (%0d in the unused mode) and %0d responses.",
               xfer_count, ignored_count, rsp_count);
      $display("Full-list drops: %0d, successful deletions: %0d, longest traverse: %0d.",
               full_drops, deletions, longest_walk);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/bol_pkg.sv
hdl/bol_cell.sv
hdl/bounded_ordered_list_unit.sv
tb/tb_top.sv
